// ===== src/abd_pkg.sv =====
// ----------------------------------------------------------------------------
// abd_pkg
// Shared types and constants of the anchor box decoder.
// ----------------------------------------------------------------------------
package abd_pkg;

   localparam int DEF_NUM_CLASSES  = 80;
   localparam int DEF_ANCHOR_SLOTS = 3;
   localparam int DEF_GRID_BITS    = 8;

   localparam int VALUE_W     = 16;
   localparam int COUNT_W     = 7;
   localparam int BOX_TERMS   = 5;
   localparam int CENTER_W    = 25;   // (2d - 0.5 + cell) in Q.15, signed
   localparam int ANCHOR_W    = 10;
   localparam int STRIDE_W    = 7;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [7:0]         cell_column;
      logic [7:0]         cell_row;
      logic [1:0]         anchor_slot;
      logic [VALUE_W-1:0] element_value;
      logic               vector_last;
   } req_type;

   typedef struct packed {
      logic signed [19:0] box_left;
      logic signed [19:0] box_top;
      logic [15:0]        box_width;
      logic [15:0]        box_height;
      logic [6:0]         class_id;
      logic [15:0]        box_score;
   } rsp_type;

   // one finished prediction vector, handed from front to back
   typedef struct packed {
      logic signed [CENTER_W-1:0] center_x;
      logic signed [CENTER_W-1:0] center_y;
      logic [VALUE_W-1:0]         term_w;
      logic [VALUE_W-1:0]         term_h;
      logic [VALUE_W-1:0]         objectness;
      logic [VALUE_W-1:0]         best_score;
      logic [COUNT_W-1:0]         best_class;
      logic [1:0]                 anchor_slot;
   } job_type;

   typedef struct packed {
      logic [VALUE_W-1:0]            score_threshold;
      logic [STRIDE_W-1:0]           grid_stride;
      logic [2:0][ANCHOR_W-1:0]      anchor_width;
      logic [2:0][ANCHOR_W-1:0]      anchor_height;
   } cfg_type;

   typedef struct packed {
      logic    push;
      logic    pop;
      logic    full;
      logic    empty;
   } queue_ctl_type;

endpackage

// ===== src/abd_front.sv =====
// ----------------------------------------------------------------------------
// abd_front
// Collects one prediction vector: box terms, objectness and running best class.
// ----------------------------------------------------------------------------
module abd_front #(
   parameter int NUM_CLASSES  = abd_pkg::DEF_NUM_CLASSES,
   parameter int ANCHOR_SLOTS = abd_pkg::DEF_ANCHOR_SLOTS,
   parameter int GRID_BITS    = abd_pkg::DEF_GRID_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  abd_pkg::req_type req_data,
   input  logic             job_full,
   output logic             job_push,
   output abd_pkg::job_type job_data
);
   import abd_pkg::*;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [VALUE_W-1:0] term_ff [BOX_TERMS];
   logic [VALUE_W-1:0] best_ff, best_in;
   logic [COUNT_W-1:0] class_ff, class_in;

   logic               accept;
   logic               is_score;
   logic [COUNT_W-1:0] class_offset;
   logic               take_best;
   logic [GRID_BITS-1:0] col_masked, row_masked;
   logic [CENTER_W-1:0]  cx_raw, cy_raw;

   assign req_ready    = !job_full;
   assign accept       = req_valid && req_ready;
   assign is_score     = count_ff >= COUNT_W'(BOX_TERMS);
   assign class_offset = count_ff - COUNT_W'(BOX_TERMS);
   assign take_best    = is_score && (class_offset < COUNT_W'(NUM_CLASSES))
                         && (req_data.element_value > best_ff);

   always_comb begin
      best_in  = take_best ? req_data.element_value : best_ff;
      class_in = take_best ? class_offset : class_ff;
      if (req_data.vector_last) begin
         count_in = '0;
      end else if (count_ff != {COUNT_W{1'b1}}) begin
         count_in = count_ff + COUNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         best_ff  <= '0;
         class_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
         best_ff  <= req_data.vector_last ? '0 : best_in;
         class_ff <= req_data.vector_last ? '0 : class_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !is_score) begin
         term_ff[count_ff[2:0]] <= req_data.element_value;
      end
   end

   // center offset 2d - 0.5 + cell, all in Q.15
   assign col_masked = req_data.cell_column[GRID_BITS-1:0];
   assign row_masked = req_data.cell_row[GRID_BITS-1:0];
   assign cx_raw = (CENTER_W'(col_masked) << 15) + (CENTER_W'(term_ff[0]) << 1)
                   - CENTER_W'(16384);
   assign cy_raw = (CENTER_W'(row_masked) << 15) + (CENTER_W'(term_ff[1]) << 1)
                   - CENTER_W'(16384);

   assign job_push = accept && req_data.vector_last && is_score;

   always_comb begin
      job_data.center_x   = $signed(cx_raw);
      job_data.center_y   = $signed(cy_raw);
      job_data.term_w     = term_ff[2];
      job_data.term_h     = term_ff[3];
      job_data.objectness = term_ff[4];
      job_data.best_score = best_in;
      job_data.best_class = class_in;
      if (req_data.anchor_slot >= 2'(ANCHOR_SLOTS)) begin
         job_data.anchor_slot = 2'(ANCHOR_SLOTS - 1);
      end else begin
         job_data.anchor_slot = req_data.anchor_slot;
      end
   end

endmodule

// ===== src/abd_queue.sv =====
// ----------------------------------------------------------------------------
// abd_queue
// Short job queue between the vector collector and the box arithmetic.
// ----------------------------------------------------------------------------
module abd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  abd_pkg::job_type       push_data,
   input  logic                   pop,
   output abd_pkg::job_type       head_data,
   output abd_pkg::queue_ctl_type status
);
   import abd_pkg::*;

   localparam int PtrW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CountW = $clog2(QUEUE_DEPTH + 1);

   job_type           slot_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CountW-1:0] count_ff, count_in;

   function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] ptr);
      if (ptr == PtrW'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + PtrW'(1);
   endfunction

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CountW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data    = slot_ff[rd_ptr_ff];
   assign status.push  = push;
   assign status.pop   = pop;
   assign status.full  = count_ff == CountW'(QUEUE_DEPTH);
   assign status.empty = count_ff == '0;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(QUEUE_DEPTH))
      else $error("job queue count beyond depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("job queue popped while empty");

endmodule

// ===== src/abd_back.sv =====
// ----------------------------------------------------------------------------
// abd_back
// Box arithmetic: registered arithmetic stages and the result register.
// ----------------------------------------------------------------------------
module abd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  abd_pkg::cfg_type       cfg,
   input  abd_pkg::job_type       job_data,
   input  abd_pkg::queue_ctl_type job_status,
   output logic                   job_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output abd_pkg::rsp_type       rsp_data
);
   import abd_pkg::*;

   logic advance;

   // stage 1: squares, center times stride, confidence product
   logic               s1_valid_ff;
   logic signed [31:0] s1_px_ff, s1_py_ff, s1_px_in, s1_py_in;
   logic [31:0]        s1_sw_ff, s1_sh_ff, s1_sw_in, s1_sh_in;
   logic [31:0]        s1_prod_ff, s1_prod_in;
   logic               s1_obj_ok_ff;
   logic [ANCHOR_W-1:0] s1_aw_ff, s1_ah_ff;
   logic [COUNT_W-1:0] s1_cls_ff;

   // stage 2: size times anchor, threshold test
   logic               s2_valid_ff;
   logic signed [31:0] s2_px_ff, s2_py_ff;
   logic [41:0]        s2_wm_ff, s2_hm_ff, s2_wm_in, s2_hm_in;
   logic [31:0]        s2_prod_ff;
   logic               s2_pass_ff, s2_pass_in;
   logic [COUNT_W-1:0] s2_cls_ff;

   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic signed [31:0] stride_ext;
   logic signed [47:0] edge_x, edge_y;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign job_pop = advance && !job_status.empty;

   assign stride_ext = $signed({25'b0, cfg.grid_stride});
   assign s1_px_in   = 32'(job_data.center_x) * stride_ext;
   assign s1_py_in   = 32'(job_data.center_y) * stride_ext;
   assign s1_sw_in   = {16'b0, job_data.term_w} * {16'b0, job_data.term_w};
   assign s1_sh_in   = {16'b0, job_data.term_h} * {16'b0, job_data.term_h};
   assign s1_prod_in = {16'b0, job_data.objectness} * {16'b0, job_data.best_score};

   assign s2_wm_in   = {10'b0, s1_sw_ff} * {32'b0, s1_aw_ff};
   assign s2_hm_in   = {10'b0, s1_sh_ff} * {32'b0, s1_ah_ff};
   assign s2_pass_in = s1_obj_ok_ff
                       && (s1_prod_ff >= {1'b0, cfg.score_threshold, 15'b0});

   function automatic logic [19:0] sat_edge(input logic signed [47:0] v);
      logic [20:0] e;
      e = v[47:27];   // arithmetic shift is a floor
      if (e[20] != e[19]) begin
         return e[20] ? 20'h80000 : 20'h7FFFF;
      end
      return e[19:0];
   endfunction

   function automatic logic [15:0] sat_size(input logic [41:0] v);
      if (v[41:40] != 2'b00) begin
         return 16'hFFFF;
      end
      return v[39:24];
   endfunction

   // center minus half size, both scaled to 2^-31 pixel
   assign edge_x = {s2_px_ff, 16'b0} - $signed({4'b0, s2_wm_ff, 2'b0});
   assign edge_y = {s2_py_ff, 16'b0} - $signed({4'b0, s2_hm_ff, 2'b0});

   always_comb begin
      rsp_data_in.box_left    = $signed(sat_edge(edge_x));
      rsp_data_in.box_top     = $signed(sat_edge(edge_y));
      rsp_data_in.box_width   = sat_size(s2_wm_ff);
      rsp_data_in.box_height  = sat_size(s2_hm_ff);
      rsp_data_in.class_id    = s2_cls_ff;
      rsp_data_in.box_score   = s2_prod_ff[31] ? 16'hFFFF : s2_prod_ff[30:15];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= !job_status.empty;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff && s2_pass_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_px_ff     <= s1_px_in;
         s1_py_ff     <= s1_py_in;
         s1_sw_ff     <= s1_sw_in;
         s1_sh_ff     <= s1_sh_in;
         s1_prod_ff   <= s1_prod_in;
         s1_obj_ok_ff <= job_data.objectness >= cfg.score_threshold;
         s1_aw_ff     <= cfg.anchor_width[job_data.anchor_slot];
         s1_ah_ff     <= cfg.anchor_height[job_data.anchor_slot];
         s1_cls_ff    <= job_data.best_class;
         s2_px_ff     <= s1_px_ff;
         s2_py_ff     <= s1_py_ff;
         s2_wm_ff     <= s2_wm_in;
         s2_hm_ff     <= s2_hm_in;
         s2_prod_ff   <= s1_prod_ff;
         s2_pass_ff   <= s2_pass_in;
         s2_cls_ff    <= s1_cls_ff;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_rsp_from_stage2: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s2_valid_ff))
      else $error("box transaction without a job in the last stage");

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> ($stable(s1_valid_ff) && $stable(s2_valid_ff)))
      else $error("pipeline moved while result stalled");

endmodule

// ===== src/anchor_box_decode.sv =====
// ----------------------------------------------------------------------------
// anchor_box_decode
// Per-anchor box decoder for one output scale of an anchor-based detector.
// ----------------------------------------------------------------------------
// Usage:
//  req_* streams one prediction value per transaction: dx, dy, dw, dh,
//  objectness, then the class scores, with vector_last on the final score.
//  One transaction per cycle is taken while the job queue has room.
//  rsp_* carries at most one box per vector, only when objectness and
//  objectness times the best score both reach score_threshold.
//  csr_* writes the threshold, stride and anchor sizes; write only while idle.
// Path: after the last value is taken, the box passes the queue register,
//  two arithmetic stages and the result register; a stall holds it.
// Throughput: one value per cycle; when not stalled, the back end takes one
//  vector per cycle: vectors of six or more values stream at full rate.
// Reset: registers return to their defaults, the vector state, queue and
//  arithmetic pipeline are emptied.
// Stall: a held rsp_ready freezes the arithmetic pipeline; the front keeps
//  collecting until the two-entry job queue is full, then drops req_ready.
// ----------------------------------------------------------------------------
module anchor_box_decode #(
   parameter int NUM_CLASSES  = abd_pkg::DEF_NUM_CLASSES,
   parameter int ANCHOR_SLOTS = abd_pkg::DEF_ANCHOR_SLOTS,
   parameter int GRID_BITS    = abd_pkg::DEF_GRID_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  abd_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output abd_pkg::rsp_type                   rsp_data,
   input  logic                               csr_write_enable,
   input  logic [abd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [abd_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import abd_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CsrThreshold = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CsrStride    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CsrAnchor0W  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CsrAnchor0H  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CsrAnchor1W  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CsrAnchor1H  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CsrAnchor2W  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CsrAnchor2H  = 3'd7;

   cfg_type       cfg_ff;
   job_type       push_data, head_data;
   logic          job_push, job_pop;
   queue_ctl_type job_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.score_threshold  <= 16'd8192;
         cfg_ff.grid_stride      <= 7'd8;
         cfg_ff.anchor_width[0]  <= 10'd10;
         cfg_ff.anchor_height[0] <= 10'd13;
         cfg_ff.anchor_width[1]  <= 10'd16;
         cfg_ff.anchor_height[1] <= 10'd30;
         cfg_ff.anchor_width[2]  <= 10'd33;
         cfg_ff.anchor_height[2] <= 10'd23;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CsrThreshold: cfg_ff.score_threshold  <= csr_write_data;
            CsrStride:    cfg_ff.grid_stride      <= csr_write_data[STRIDE_W-1:0];
            CsrAnchor0W:  cfg_ff.anchor_width[0]  <= csr_write_data[ANCHOR_W-1:0];
            CsrAnchor0H:  cfg_ff.anchor_height[0] <= csr_write_data[ANCHOR_W-1:0];
            CsrAnchor1W:  cfg_ff.anchor_width[1]  <= csr_write_data[ANCHOR_W-1:0];
            CsrAnchor1H:  cfg_ff.anchor_height[1] <= csr_write_data[ANCHOR_W-1:0];
            CsrAnchor2W:  cfg_ff.anchor_width[2]  <= csr_write_data[ANCHOR_W-1:0];
            CsrAnchor2H:  cfg_ff.anchor_height[2] <= csr_write_data[ANCHOR_W-1:0];
            default:      cfg_ff <= cfg_ff;
         endcase
      end
   end

   abd_front #(
      .NUM_CLASSES  (NUM_CLASSES),
      .ANCHOR_SLOTS (ANCHOR_SLOTS),
      .GRID_BITS    (GRID_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .job_full  (job_status.full),
      .job_push  (job_push),
      .job_data  (push_data)
   );

   abd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_data),
      .pop       (job_pop),
      .head_data (head_data),
      .status    (job_status)
   );

   abd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .job_data   (head_data),
      .job_status (job_status),
      .job_pop    (job_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
